// ----- hw/rtl/cmt_pkg.sv -----
// Shared types and constants of the compare-match timer.
package cmt_pkg;

   localparam int unsigned OfsW   = 12;
   localparam int unsigned SizeW  = 4;
   localparam int unsigned DataW  = 64;
   localparam int unsigned HalfW  = 32;
   localparam int unsigned FreqW  = 32;

   localparam logic [OfsW-1:0]  OFS_FREQ       = 12'h000;
   localparam logic [OfsW-1:0]  OFS_ENABLE     = 12'h004;
   localparam logic [OfsW-1:0]  OFS_COUNT      = 12'h008;
   localparam logic [OfsW-1:0]  OFS_COUNT_HI   = 12'h00C;
   localparam logic [OfsW-1:0]  OFS_COMPARE    = 12'h010;
   localparam logic [OfsW-1:0]  OFS_COMPARE_HI = 12'h014;

   localparam logic [SizeW-1:0] SIZE_WORD  = 4'd4;
   localparam logic [SizeW-1:0] SIZE_DWORD = 4'd8;

   localparam logic [FreqW-1:0] FREQ_RESET = 32'd1000000000;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_IDLE  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_TICK,
      OP_RD_FREQ,
      OP_RD_CNT_LO,
      OP_RD_CNT,
      OP_RD_CNT_HI,
      OP_WR_EN,
      OP_WR_CMP_LO,
      OP_WR_CMP,
      OP_WR_CMP_HI
   } op_code_type;

   typedef struct packed {
      op_code_type op;
      logic        bad;
   } op_type;

   // Request payload; last member sits in the lowest bits.
   typedef struct packed {
      logic [DataW-1:0] write_data;
      logic [SizeW-1:0] access_bytes;
      logic [OfsW-1:0]  reg_offset;
   } req_item_type;

   typedef struct packed {
      logic             irq_level;
      logic             bad_access;
      logic [DataW-1:0] read_data;
   } rsp_item_type;

endpackage

// ----- hw/rtl/cmt_decode.sv -----
// Access decoder: maps command, offset and size onto one operation.
module cmt_decode (
   input  logic [1:0]                   cmd,
   input  logic [cmt_pkg::OfsW-1:0]     reg_offset,
   input  logic [cmt_pkg::SizeW-1:0]    access_bytes,
   output cmt_pkg::op_type              op
);

   logic is_word;
   logic is_dword;

   assign is_word  = (access_bytes == cmt_pkg::SIZE_WORD);
   assign is_dword = (access_bytes == cmt_pkg::SIZE_DWORD);

   always_comb begin
      op.op  = cmt_pkg::OP_NONE;
      op.bad = 1'b0;
      case (cmt_pkg::cmd_type'(cmd))
         cmt_pkg::CMD_TICK: begin
            op.op = cmt_pkg::OP_TICK;
         end
         cmt_pkg::CMD_READ: begin
            if (reg_offset == cmt_pkg::OFS_FREQ && is_word) begin
               op.op = cmt_pkg::OP_RD_FREQ;
            end else if (reg_offset == cmt_pkg::OFS_COUNT && is_word) begin
               op.op = cmt_pkg::OP_RD_CNT_LO;
            end else if (reg_offset == cmt_pkg::OFS_COUNT && is_dword) begin
               op.op = cmt_pkg::OP_RD_CNT;
            end else if (reg_offset == cmt_pkg::OFS_COUNT_HI && is_word) begin
               op.op = cmt_pkg::OP_RD_CNT_HI;
            end else begin
               op.bad = 1'b1;
            end
         end
         cmt_pkg::CMD_WRITE: begin
            if (reg_offset == cmt_pkg::OFS_ENABLE && is_word) begin
               op.op = cmt_pkg::OP_WR_EN;
            end else if (reg_offset == cmt_pkg::OFS_COMPARE && is_word) begin
               op.op = cmt_pkg::OP_WR_CMP_LO;
            end else if (reg_offset == cmt_pkg::OFS_COMPARE && is_dword) begin
               op.op = cmt_pkg::OP_WR_CMP;
            end else if (reg_offset == cmt_pkg::OFS_COMPARE_HI && is_word) begin
               op.op = cmt_pkg::OP_WR_CMP_HI;
            end else begin
               op.bad = 1'b1;
            end
         end
         default: begin
            op.op = cmt_pkg::OP_NONE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/cmt_state.sv -----
// Timer state: count, compare, enable, frequency word, read mux and irq.
module cmt_state (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       exec,
   input  cmt_pkg::op_type            op,
   input  logic [cmt_pkg::DataW-1:0]  write_data,
   input  logic                       csr_wen,
   input  logic [cmt_pkg::FreqW-1:0]  csr_wdata,
   output logic [cmt_pkg::DataW-1:0]  read_data,
   output logic                       irq_next
);

   logic [cmt_pkg::DataW-1:0] count_ff;
   logic [cmt_pkg::DataW-1:0] count_in;
   logic [cmt_pkg::DataW-1:0] compare_ff;
   logic [cmt_pkg::DataW-1:0] compare_in;
   logic                      on_ff;
   logic                      on_in;
   logic [cmt_pkg::FreqW-1:0] freq_ff;

   always_comb begin
      count_in   = count_ff;
      compare_in = compare_ff;
      on_in      = on_ff;
      if (exec) begin
         case (op.op)
            cmt_pkg::OP_TICK:      count_in = count_ff + 64'd1;
            cmt_pkg::OP_WR_EN:     on_in = |write_data;
            cmt_pkg::OP_WR_CMP_LO: compare_in = {compare_ff[cmt_pkg::DataW-1:cmt_pkg::HalfW],
                                                 write_data[cmt_pkg::HalfW-1:0]};
            cmt_pkg::OP_WR_CMP:    compare_in = write_data;
            cmt_pkg::OP_WR_CMP_HI: compare_in = {write_data[cmt_pkg::HalfW-1:0],
                                                 compare_ff[cmt_pkg::HalfW-1:0]};
            default: ;
         endcase
      end
   end

   // Reads see the state before this beat; reads never change it.
   always_comb begin
      case (op.op)
         cmt_pkg::OP_RD_FREQ:   read_data = {{(cmt_pkg::DataW-cmt_pkg::FreqW){1'b0}}, freq_ff};
         cmt_pkg::OP_RD_CNT_LO: read_data = {{cmt_pkg::HalfW{1'b0}},
                                            count_ff[cmt_pkg::HalfW-1:0]};
         cmt_pkg::OP_RD_CNT:    read_data = count_ff;
         cmt_pkg::OP_RD_CNT_HI: read_data = {{cmt_pkg::HalfW{1'b0}},
                                            count_ff[cmt_pkg::DataW-1:cmt_pkg::HalfW]};
         default:               read_data = '0;
      endcase
   end

   assign irq_next = on_in && (count_in >= compare_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         compare_ff <= '0;
         on_ff      <= 1'b0;
         freq_ff    <= cmt_pkg::FREQ_RESET;
      end else begin
         count_ff   <= count_in;
         compare_ff <= compare_in;
         on_ff      <= on_in;
         if (csr_wen) begin
            freq_ff <= csr_wdata;
         end
      end
   end

`ifndef SYNTHESIS
   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      !reset && exec && op.op == cmt_pkg::OP_TICK |=> count_ff == $past(count_ff) + 64'd1)
      else $error("count did not advance on tick");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !reset && !exec |=> $stable(count_ff) && $stable(compare_ff) && $stable(on_ff))
      else $error("timer state changed without an executed beat");

   a_bad_no_effect: assert property (@(posedge clock) disable iff (reset)
      !reset && exec && op.bad |=> $stable(count_ff) && $stable(compare_ff) && $stable(on_ff))
      else $error("rejected access changed timer state");

   a_bad_reads_zero: assert property (@(posedge clock) disable iff (reset)
      op.bad |-> read_data == '0)
      else $error("rejected access returned data");
`endif

endmodule

// ----- hw/rtl/compare_match_timer.sv -----
// Top level of the compare-match timer: input stage, decode, state and result stage.
//
//   channel | dir | beat contents
//   req_    | in  | tuser: cmd; tdata: reg_offset, access_bytes, write_data
//   rsp_    | out | tdata: read_data; tuser: bad_access, irq_level
//   csr_    | in  | wen + wdata: tick_frequency
//
// One beat per clock sustained while the response is not stalled; a request
// beat passes the input register, then the result register, before it is
// offered as a response.
// The execute step between the two registers does decode, the 64-bit count
// increment and the 64-bit count/compare check that sets irq_level.
// Reset is synchronous: count, compare and enable clear, frequency reloads 1e9.
// A stalled response holds the result register; the input register still
// takes one more beat, then req_tready drops until the response moves.
module compare_match_timer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   input  logic [79:0] req_tdata,   // [11:0] reg_offset, [15:12] access_bytes,
                                    // [79:16] write_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] read_data
   output logic [1:0]  rsp_tuser,   // [0] bad_access, [1] irq_level
   input  logic        csr_wen,
   input  logic [31:0] csr_wdata
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [1:0]            in_cmd_ff;
   cmt_pkg::req_item_type in_item_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   cmt_pkg::rsp_item_type rsp_item_ff;
   cmt_pkg::rsp_item_type rsp_item_in;
   cmt_pkg::op_type       op;
   logic                  advance;
   logic                  accept;
   logic                  exec;
   logic [63:0]           read_data;
   logic                  irq_next;

   // Result stage moves when it is empty or its beat is taken.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign exec       = in_valid_ff && advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on accept / execute, hold otherwise.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff  <= req_tuser;
         in_item_ff <= cmt_pkg::req_item_type'(req_tdata);
      end
      if (exec) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   cmt_decode u_decode (
      .cmd          (in_cmd_ff),
      .reg_offset   (in_item_ff.reg_offset),
      .access_bytes (in_item_ff.access_bytes),
      .op           (op)
   );

   cmt_state u_state (
      .clock      (clock),
      .reset      (reset),
      .exec       (exec),
      .op         (op),
      .write_data (in_item_ff.write_data),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .read_data  (read_data),
      .irq_next   (irq_next)
   );

   always_comb begin
      rsp_item_in.read_data  = read_data;
      rsp_item_in.bad_access = op.bad;
      rsp_item_in.irq_level  = irq_next;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff.read_data;
   assign rsp_tuser  = {rsp_item_ff.irq_level, rsp_item_ff.bad_access};

`ifndef SYNTHESIS
   a_hold_pending: assert property (@(posedge clock) disable iff (reset)
      !reset && in_valid_ff && rsp_valid_ff && !rsp_tready |=> in_valid_ff)
      else $error("pending request dropped while response stalled");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken with both stages full");

   a_exec_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      !reset && exec |=> rsp_valid_ff)
      else $error("executed beat produced no response");
`endif

endmodule

// ----- bench/cmt_checker.sv -----
// Checker of the compare-match timer: predicts each response and compares it.
`timescale 1ns / 100ps

module cmt_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [1:0]  req_tuser,
   input  logic [79:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_wen,
   input  logic [31:0] csr_wdata,
   output int          outstanding,
   output int          fail_count
);

   logic [cmt_pkg::FreqW-1:0] freq_word;
   logic [cmt_pkg::DataW-1:0] count_now;
   logic [cmt_pkg::DataW-1:0] compare_now;
   logic                      timer_enabled;
   cmt_pkg::rsp_item_type     due_rsp_q[$];

   // Apply one request beat to the timer state and queue the response it yields.
   task automatic step_timer(input cmt_pkg::cmd_type cmd,
                             input cmt_pkg::req_item_type req);
      cmt_pkg::rsp_item_type due;
      due = '0;
      case (cmd)
         cmt_pkg::CMD_TICK: count_now = count_now + 64'd1;
         cmt_pkg::CMD_READ: begin
            if (req.reg_offset == cmt_pkg::OFS_FREQ
                && req.access_bytes == cmt_pkg::SIZE_WORD)
               due.read_data = {32'd0, freq_word};
            else if (req.reg_offset == cmt_pkg::OFS_COUNT
                     && req.access_bytes == cmt_pkg::SIZE_WORD)
               due.read_data = {32'd0, count_now[31:0]};
            else if (req.reg_offset == cmt_pkg::OFS_COUNT
                     && req.access_bytes == cmt_pkg::SIZE_DWORD)
               due.read_data = count_now;
            else if (req.reg_offset == cmt_pkg::OFS_COUNT_HI
                     && req.access_bytes == cmt_pkg::SIZE_WORD)
               due.read_data = {32'd0, count_now[63:32]};
            else
               due.bad_access = 1'b1;
         end
         cmt_pkg::CMD_WRITE: begin
            if (req.reg_offset == cmt_pkg::OFS_ENABLE
                && req.access_bytes == cmt_pkg::SIZE_WORD)
               timer_enabled = (req.write_data != '0);
            else if (req.reg_offset == cmt_pkg::OFS_COMPARE
                     && req.access_bytes == cmt_pkg::SIZE_WORD)
               compare_now[31:0] = req.write_data[31:0];
            else if (req.reg_offset == cmt_pkg::OFS_COMPARE
                     && req.access_bytes == cmt_pkg::SIZE_DWORD)
               compare_now = req.write_data;
            else if (req.reg_offset == cmt_pkg::OFS_COMPARE_HI
                     && req.access_bytes == cmt_pkg::SIZE_WORD)
               compare_now[63:32] = req.write_data[31:0];
            else
               due.bad_access = 1'b1;
         end
         default: ;
      endcase
      due.irq_level = timer_enabled && (count_now >= compare_now);
      due_rsp_q.push_back(due);
   endtask

   task automatic check_rsp(input cmt_pkg::rsp_item_type got);
      cmt_pkg::rsp_item_type due;
      if (due_rsp_q.size() == 0) begin
         $display("%0t: response beat with none pending: expected nothing, actual %h",
                  $time, got);
         fail_count++;
      end else begin
         due = due_rsp_q.pop_front();
         if (got.read_data !== due.read_data) begin
            $display("%0t: read_data mismatch: expected %h, actual %h",
                     $time, due.read_data, got.read_data);
            fail_count++;
         end
         if (got.bad_access !== due.bad_access) begin
            $display("%0t: bad_access mismatch: expected %b, actual %b",
                     $time, due.bad_access, got.bad_access);
            fail_count++;
         end
         if (got.irq_level !== due.irq_level) begin
            $display("%0t: irq_level mismatch: expected %b, actual %b",
                     $time, due.irq_level, got.irq_level);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         freq_word     = cmt_pkg::FREQ_RESET;
         count_now     = '0;
         compare_now   = '0;
         timer_enabled = 1'b0;
         fail_count    = 0;
         due_rsp_q.delete();
      end else begin
         if (csr_wen)
            freq_word = csr_wdata;
         if (req_tvalid && req_tready)
            step_timer(cmt_pkg::cmd_type'(req_tuser), cmt_pkg::req_item_type'(req_tdata));
         if (rsp_tvalid && rsp_tready)
            check_rsp('{irq_level: rsp_tuser[1], bad_access: rsp_tuser[0],
                        read_data: rsp_tdata});
      end
      outstanding = due_rsp_q.size();
   end

endmodule

// ----- bench/tb_compare_match_timer.sv -----
// Testbench top of the compare-match timer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_compare_match_timer;

   localparam int HoldCycles = 300;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;   // [1:0] cmd
   logic [79:0] req_tdata;   // [11:0] reg_offset, [15:12] access_bytes, [79:16] write_data
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [63:0] read_data
   logic [1:0]  rsp_tuser;   // [0] bad_access, [1] irq_level
   logic        csr_wen;
   logic [31:0] csr_wdata;

   int          rsp_owed;
   int          mismatch_total;

   // Random idling on both sides; cleared for one long stretch.
   bit          gaps_on = 1'b1;
   // Ask the response side for one long hold-off.
   bit          hold_rsp = 1'b0;
   // Ticks sent so far; only used to aim compare values near the live count.
   logic [63:0] ticks_sent = '0;

   compare_match_timer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   cmt_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .outstanding (rsp_owed),
      .fail_count  (mismatch_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a response never shows up.
   initial begin
      #(2_000_000);
      $display("Regression FAIL");
      $finish;
   end

   // Response side: random stalls, plus one long hold-off on request so the
   // input register fills and req_tready has to drop.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            for (int k = 0; k < HoldCycles; k++) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_tready <= !(gaps_on && $urandom_range(99) < 33);
      end
   end

   // Offer one request beat, with random idle cycles ahead of it, and hold it
   // until the block takes it. Valid stays high for the caller's next beat.
   task automatic send_beat(input cmt_pkg::cmd_type cmd,
                            input logic [cmt_pkg::OfsW-1:0] ofs,
                            input logic [cmt_pkg::SizeW-1:0] bytes,
                            input logic [cmt_pkg::DataW-1:0] data);
      cmt_pkg::req_item_type beat;
      beat = '{write_data: data, access_bytes: bytes, reg_offset: ofs};
      while (gaps_on && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
      if (cmd == cmt_pkg::CMD_TICK)
         ticks_sent = ticks_sent + 64'd1;
   endtask

   // Drop valid and wait for every outstanding response. The extra edge lets
   // the checker count the beat taken at this very edge before we look.
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (rsp_owed != 0)
         @(posedge clock);
   endtask

   // Reprogram the reported frequency while the block is idle.
   task automatic set_frequency(input logic [cmt_pkg::FreqW-1:0] freq);
      drain();
      csr_wen   <= 1'b1;
      csr_wdata <= freq;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   // Random beats: mostly ticks and legal register accesses, with compare
   // values aimed close to the live count so irq_level keeps flipping, and
   // some noise (any command, offset and size).
   task automatic run_phase(input int n_beats, input int hold_at);
      int          pick;
      logic [63:0] aim;
      logic [63:0] rnd;
      for (int n = 0; n < n_beats; n++) begin
         if (n == hold_at)
            hold_rsp = 1'b1;
         pick = $urandom_range(99);
         rnd  = {$urandom, $urandom};
         aim  = ticks_sent + 64'($urandom_range(40)) - 64'd10;
         if ($urandom_range(9) == 0)
            aim = rnd;
         if (pick < 45) begin
            send_beat(cmt_pkg::CMD_TICK, 12'($urandom_range(4095)),
                      4'($urandom_range(15)), rnd);
         end else if (pick < 65) begin
            case ($urandom_range(3))
               0: send_beat(cmt_pkg::CMD_READ, cmt_pkg::OFS_FREQ, cmt_pkg::SIZE_WORD, rnd);
               1: send_beat(cmt_pkg::CMD_READ, cmt_pkg::OFS_COUNT, cmt_pkg::SIZE_WORD, rnd);
               2: send_beat(cmt_pkg::CMD_READ, cmt_pkg::OFS_COUNT, cmt_pkg::SIZE_DWORD, rnd);
               default: send_beat(cmt_pkg::CMD_READ, cmt_pkg::OFS_COUNT_HI,
                                  cmt_pkg::SIZE_WORD, rnd);
            endcase
         end else if (pick < 85) begin
            case ($urandom_range(3))
               0: send_beat(cmt_pkg::CMD_WRITE, cmt_pkg::OFS_ENABLE, cmt_pkg::SIZE_WORD,
                            ($urandom_range(4) == 0) ? 64'd0 : rnd);
               1: send_beat(cmt_pkg::CMD_WRITE, cmt_pkg::OFS_COMPARE, cmt_pkg::SIZE_WORD,
                            {rnd[63:32], aim[31:0]});
               2: send_beat(cmt_pkg::CMD_WRITE, cmt_pkg::OFS_COMPARE, cmt_pkg::SIZE_DWORD,
                            aim);
               default: send_beat(cmt_pkg::CMD_WRITE, cmt_pkg::OFS_COMPARE_HI,
                                  cmt_pkg::SIZE_WORD, {rnd[63:32], aim[63:32]});
            endcase
         end else if (pick < 92) begin
            // near-miss offsets: word aligned inside the window
            send_beat(cmt_pkg::cmd_type'($urandom_range(3)), 12'($urandom_range(7) * 4),
                      4'($urandom_range(15)), rnd);
         end else begin
            send_beat(cmt_pkg::cmd_type'($urandom_range(3)), 12'($urandom_range(4095)),
                      4'($urandom_range(15)), rnd);
         end
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= cmt_pkg::CMD_IDLE;
      req_tdata  <= '0;
      csr_wen    <= 1'b0;
      csr_wdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset values, every legal register, the compare edge,
      // the unused command and a spread of rejected offset/size pairs.
      send_beat(cmt_pkg::CMD_READ, cmt_pkg::OFS_FREQ, cmt_pkg::SIZE_WORD, '0);
      send_beat(cmt_pkg::CMD_READ, cmt_pkg::OFS_COUNT, cmt_pkg::SIZE_WORD, '0);
      send_beat(cmt_pkg::CMD_READ, cmt_pkg::OFS_COUNT, cmt_pkg::SIZE_DWORD, '1);
      send_beat(cmt_pkg::CMD_READ, cmt_pkg::OFS_COUNT_HI, cmt_pkg::SIZE_WORD, '0);
      send_beat(cmt_pkg::CMD_TICK, '0, '0, '0);
      send_beat(cmt_pkg::CMD_TICK, '1, '1, '1);
      send_beat(cmt_pkg::CMD_READ, cmt_pkg::OFS_COUNT, cmt_pkg::SIZE_DWORD, '0);
      // enabled with compare at zero: irq rises at once
      send_beat(cmt_pkg::CMD_WRITE, cmt_pkg::OFS_ENABLE, cmt_pkg::SIZE_WORD, 64'd1);
      send_beat(cmt_pkg::CMD_WRITE, cmt_pkg::OFS_COMPARE, cmt_pkg::SIZE_DWORD, '1);
      send_beat(cmt_pkg::CMD_WRITE, cmt_pkg::OFS_COMPARE, cmt_pkg::SIZE_WORD,
                64'hFFFF_FFFF_0000_0003);
      send_beat(cmt_pkg::CMD_WRITE, cmt_pkg::OFS_COMPARE_HI, cmt_pkg::SIZE_WORD,
                64'hAAAA_AAAA_0000_0000);
      // count meets compare exactly on this tick
      send_beat(cmt_pkg::CMD_TICK, '0, '0, '0);
      send_beat(cmt_pkg::CMD_WRITE, cmt_pkg::OFS_ENABLE, cmt_pkg::SIZE_WORD,
                64'h1_0000_0000);
      send_beat(cmt_pkg::CMD_WRITE, cmt_pkg::OFS_ENABLE, cmt_pkg::SIZE_WORD, 64'd0);
      send_beat(cmt_pkg::CMD_IDLE, cmt_pkg::OFS_COUNT, cmt_pkg::SIZE_DWORD,
                64'h5555_5555_5555_5555);
      send_beat(cmt_pkg::CMD_READ, cmt_pkg::OFS_ENABLE, cmt_pkg::SIZE_WORD, '0);
      send_beat(cmt_pkg::CMD_READ, cmt_pkg::OFS_FREQ, cmt_pkg::SIZE_DWORD, '0);
      send_beat(cmt_pkg::CMD_READ, cmt_pkg::OFS_COUNT, 4'd0, '0);
      send_beat(cmt_pkg::CMD_READ, 12'hFFF, 4'hF, '1);
      send_beat(cmt_pkg::CMD_READ, cmt_pkg::OFS_COMPARE, cmt_pkg::SIZE_WORD, '0);
      send_beat(cmt_pkg::CMD_WRITE, cmt_pkg::OFS_FREQ, cmt_pkg::SIZE_WORD, '1);
      send_beat(cmt_pkg::CMD_WRITE, cmt_pkg::OFS_COMPARE_HI, cmt_pkg::SIZE_DWORD, '1);
      send_beat(cmt_pkg::CMD_WRITE, cmt_pkg::OFS_COUNT_HI, cmt_pkg::SIZE_WORD, '1);
      send_beat(cmt_pkg::CMD_WRITE, cmt_pkg::OFS_COMPARE, 4'hF, '0);
      send_beat(cmt_pkg::CMD_WRITE, cmt_pkg::OFS_ENABLE, cmt_pkg::SIZE_WORD, '1);

      // Random phases, each under its own frequency word.
      set_frequency('0);
      run_phase(350, 100);
      set_frequency('1);
      gaps_on = 1'b0;
      run_phase(400, -1);
      gaps_on = 1'b1;
      set_frequency($urandom);
      run_phase(400, -1);
      set_frequency(cmt_pkg::FREQ_RESET);
      run_phase(575, -1);

      // Let the pipeline empty, then give a stray beat time to show up.
      drain();
      repeat (8) @(posedge clock);
      if (mismatch_total == 0 && rsp_owed == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
